>>> hw/rtl/moving_sphere_collision_time_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving sphere collision time block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOVING_SPHERE_COLLISION_TIME_ASSERT_SVH
`define MOVING_SPHERE_COLLISION_TIME_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MSCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/msct_pkg.sv
// ----------------------------------------------------------------------------
// msct_pkg
// Shared types, constants and the multiply sequence for the collision block.
// ----------------------------------------------------------------------------
package msct_pkg;

	localparam int POS_WIDTH  = 24;
	localparam int FAR_BITS   = 20;
	localparam int P_WIDTH    = FAR_BITS + 1;
	localparam int FAR_LIMIT  = 1 << FAR_BITS;
	localparam int HEAD_LIMIT = 16384;
	localparam int IN_BITS    = 3 * POS_WIDTH + 5 * 16;
	localparam int IN_BYTES   = (IN_BITS + 7) / 8;
	localparam logic [15:0] HORIZON_RESET = 16'd49152;

	// multiply steps: first group builds W, A, B, C; second group builds Disc
	localparam int MUL1_STEPS = 16;
	localparam int MUL2_END   = 24;
	localparam int SQRT_ITERS = 55;
	localparam int DIV_ITERS  = 16;

	typedef enum logic [4:0] {
		OP_ZERO, OP_H0X, OP_H0Y, OP_H0Z, OP_S0, OP_H1X, OP_H1Y, OP_H1Z, OP_S1,
		OP_WX, OP_WY, OP_WZ, OP_PX, OP_PY, OP_PZ, OP_D,
		OP_BLO, OP_BHI, OP_ALO, OP_AHI, OP_CLO, OP_CHI
	} opnd_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_W0, DST_W1, DST_W2, DST_A, DST_B, DST_C, DST_DISC
	} dst_t;

	typedef enum logic [1:0] {SH_0, SH_32, SH_64} shift_t;

	typedef struct packed {
		opnd_t  sel_a;
		opnd_t  sel_b;
		dst_t   dst;
		logic   sub;
		logic   negc;
		shift_t sh;
	} uop_t;

	typedef struct packed {
		logic       load_first;
		logic       load_second;
		logic       mul_en;
		logic [4:0] step;
		logic       abs_en;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       root_en;
		logic       div_init;
		logic       div_step;
		logic       q_clr;
		logic       out_write;
	} cmd_t;

	typedef struct packed {
		logic far;
		logic a_zero;
		logic disc_neg;
		logic no_root;
		logic too_big;
	} status_t;

	// saturate a heading component to the unit range
	function automatic logic signed [15:0] head_sat(logic [15:0] v);
		logic signed [15:0] h;
		h = $signed(v);
		if (h > 16'(HEAD_LIMIT))
			return 16'(HEAD_LIMIT);
		if (h < -16'(HEAD_LIMIT))
			return -16'(HEAD_LIMIT);
		return h;
	endfunction

	function automatic uop_t uop_mk(opnd_t a, opnd_t b, dst_t d, logic s, logic n, shift_t sh);
		uop_t u;
		u.sel_a = a;
		u.sel_b = b;
		u.dst   = d;
		u.sub   = s;
		u.negc  = n;
		u.sh    = sh;
		return u;
	endfunction

	// multiply sequence, one product per step
	function automatic uop_t ucode(logic [4:0] idx);
		uop_t u;
		unique case (idx)
			5'd0:    u = uop_mk(OP_H0X, OP_S0,  DST_W0,   1'b0, 1'b0, SH_0);
			5'd1:    u = uop_mk(OP_H1X, OP_S1,  DST_W0,   1'b1, 1'b0, SH_0);
			5'd2:    u = uop_mk(OP_H0Y, OP_S0,  DST_W1,   1'b0, 1'b0, SH_0);
			5'd3:    u = uop_mk(OP_H1Y, OP_S1,  DST_W1,   1'b1, 1'b0, SH_0);
			5'd4:    u = uop_mk(OP_H0Z, OP_S0,  DST_W2,   1'b0, 1'b0, SH_0);
			5'd5:    u = uop_mk(OP_H1Z, OP_S1,  DST_W2,   1'b1, 1'b0, SH_0);
			5'd6:    u = uop_mk(OP_WX,  OP_WX,  DST_A,    1'b0, 1'b0, SH_0);
			5'd7:    u = uop_mk(OP_WY,  OP_WY,  DST_A,    1'b0, 1'b0, SH_0);
			5'd8:    u = uop_mk(OP_WZ,  OP_WZ,  DST_A,    1'b0, 1'b0, SH_0);
			5'd9:    u = uop_mk(OP_PX,  OP_WX,  DST_B,    1'b0, 1'b0, SH_0);
			5'd10:   u = uop_mk(OP_PY,  OP_WY,  DST_B,    1'b0, 1'b0, SH_0);
			5'd11:   u = uop_mk(OP_PZ,  OP_WZ,  DST_B,    1'b0, 1'b0, SH_0);
			5'd12:   u = uop_mk(OP_PX,  OP_PX,  DST_C,    1'b0, 1'b0, SH_0);
			5'd13:   u = uop_mk(OP_PY,  OP_PY,  DST_C,    1'b0, 1'b0, SH_0);
			5'd14:   u = uop_mk(OP_PZ,  OP_PZ,  DST_C,    1'b0, 1'b0, SH_0);
			5'd15:   u = uop_mk(OP_D,   OP_D,   DST_C,    1'b1, 1'b0, SH_0);
			5'd16:   u = uop_mk(OP_BLO, OP_BLO, DST_DISC, 1'b0, 1'b0, SH_0);
			5'd17:   u = uop_mk(OP_BLO, OP_BHI, DST_DISC, 1'b0, 1'b0, SH_32);
			5'd18:   u = uop_mk(OP_BHI, OP_BLO, DST_DISC, 1'b0, 1'b0, SH_32);
			5'd19:   u = uop_mk(OP_BHI, OP_BHI, DST_DISC, 1'b0, 1'b0, SH_64);
			5'd20:   u = uop_mk(OP_ALO, OP_CLO, DST_DISC, 1'b0, 1'b1, SH_0);
			5'd21:   u = uop_mk(OP_ALO, OP_CHI, DST_DISC, 1'b0, 1'b1, SH_32);
			5'd22:   u = uop_mk(OP_AHI, OP_CLO, DST_DISC, 1'b0, 1'b1, SH_32);
			5'd23:   u = uop_mk(OP_AHI, OP_CHI, DST_DISC, 1'b0, 1'b1, SH_64);
			default: u = uop_mk(OP_ZERO, OP_ZERO, DST_NONE, 1'b0, 1'b0, SH_0);
		endcase
		return u;
	endfunction

endpackage

>>> hw/rtl/msct_ctrl.sv
// ----------------------------------------------------------------------------
// msct_ctrl
// Sequencer: steps the datapath through products, square root and division.
// ----------------------------------------------------------------------------
module msct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  logic              m_tready,
	output logic              m_tvalid,
	input  msct_pkg::status_t status,
	output msct_pkg::cmd_t    cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MUL1   = 10'b0000000010,
		ST_ABS    = 10'b0000000100,
		ST_MUL2   = 10'b0000001000,
		ST_SQCHK  = 10'b0000010000,
		ST_SQRT   = 10'b0000100000,
		ST_ROOT   = 10'b0001000000,
		ST_DIVCHK = 10'b0010000000,
		ST_DIV    = 10'b0100000000,
		ST_FIN    = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       out_valid_q;
	logic       s_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.step = cnt_q[4:0];
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && !s_tuser) begin
					cmd.load_first = 1'b1;
				end else if (s_acc) begin
					cmd.load_second = 1'b1;
					cnt_d   = '0;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(msct_pkg::MUL1_STEPS)) begin
					state_d = ST_ABS;
				end else begin
					cmd.mul_en = 1'b1;
				end
			end
			ST_ABS: begin
				cmd.abs_en = 1'b1;
				cnt_d = 6'(msct_pkg::MUL1_STEPS);
				if (status.far || status.a_zero) begin
					cmd.q_clr = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_MUL2;
				end
			end
			ST_MUL2: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(msct_pkg::MUL2_END)) begin
					state_d = ST_SQCHK;
				end else begin
					cmd.mul_en = 1'b1;
				end
			end
			ST_SQCHK: begin
				cnt_d = '0;
				if (status.disc_neg) begin
					cmd.q_clr = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.sqrt_init = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(msct_pkg::SQRT_ITERS - 1))
					state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_en = 1'b1;
				if (status.no_root) begin
					cmd.q_clr = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_DIVCHK;
				end
			end
			ST_DIVCHK: begin
				cnt_d = '0;
				if (status.too_big) begin
					cmd.q_clr = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(msct_pkg::DIV_ITERS - 1))
					state_d = ST_FIN;
			end
			ST_FIN: begin
				// hand the result over once the output register is free
				if (!out_valid_q || m_tready) begin
					cmd.out_write = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_write)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/msct_dp.sv
// ----------------------------------------------------------------------------
// msct_dp
// Datapath: held body, shared multiplier with accumulators, square root,
// root select and divider.
// ----------------------------------------------------------------------------
module msct_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [8*msct_pkg::IN_BYTES-1:0]    s_tdata,
	input  logic                               cfg_we,
	input  logic [15:0]                        cfg_wdata,
	input  msct_pkg::cmd_t                     cmd,
	output msct_pkg::status_t                  status,
	output logic [15:0]                        out_time
);

	localparam int PW = msct_pkg::POS_WIDTH;
	localparam int QW = msct_pkg::P_WIDTH;

	// input unpack
	logic signed [PW-1:0] in_pos  [3];
	logic        [15:0]   in_head [3];
	logic        [15:0]   in_speed, in_radius;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i]  = s_tdata[i*PW +: PW];
			in_head[i] = s_tdata[3*PW + i*16 +: 16];
		end
		in_speed  = s_tdata[3*PW + 48 +: 16];
		in_radius = s_tdata[3*PW + 64 +: 16];
	end

	// held first body and second body operands
	logic signed [PW-1:0] pos0_q [3];
	logic signed [15:0]   h0_q   [3];
	logic        [15:0]   s0_q, r0_q;
	logic signed [15:0]   h1_q   [3];
	logic        [15:0]   s1_q;
	logic signed [QW-1:0] p_q    [3];
	logic        [16:0]   d_q;
	logic                 far_q;
	logic        [15:0]   horizon_q;

	logic signed [PW:0]   diff [3];
	logic                 far_now;

	always_comb begin
		far_now = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = (PW+1)'(pos0_q[i]) - (PW+1)'(in_pos[i]);
			if (diff[i] >= msct_pkg::FAR_LIMIT || diff[i] <= -msct_pkg::FAR_LIMIT)
				far_now = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos0_q[i] <= '0;
				h0_q[i]   <= '0;
			end
			s0_q      <= '0;
			r0_q      <= '0;
			horizon_q <= msct_pkg::HORIZON_RESET;
		end else begin
			if (cmd.load_first) begin
				for (int i = 0; i < 3; i++) begin
					pos0_q[i] <= in_pos[i];
					h0_q[i]   <= msct_pkg::head_sat(in_head[i]);
				end
				s0_q <= in_speed;
				r0_q <= in_radius;
			end
			if (cfg_we)
				horizon_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_second) begin
			for (int i = 0; i < 3; i++) begin
				h1_q[i] <= msct_pkg::head_sat(in_head[i]);
				p_q[i]  <= QW'(diff[i]);
			end
			s1_q  <= in_speed;
			d_q   <= 17'(r0_q) + 17'(in_radius);
			far_q <= far_now;
		end
	end

	// shared multiplier, one product per cycle
	msct_pkg::uop_t     uop, uop_s1;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_s1;

	logic signed [31:0]  w_q [3];
	logic        [63:0]  a_q;
	logic signed [53:0]  b_q;
	logic signed [43:0]  c_q;
	logic signed [109:0] disc_q;
	logic        [53:0]  babs_q;
	logic        [43:0]  cabs_q;
	logic                c_nonneg_q;

	function automatic logic signed [32:0] opnd_val(msct_pkg::opnd_t sel);
		case (sel)
			msct_pkg::OP_H0X: return 33'(h0_q[0]);
			msct_pkg::OP_H0Y: return 33'(h0_q[1]);
			msct_pkg::OP_H0Z: return 33'(h0_q[2]);
			msct_pkg::OP_S0:  return {17'b0, s0_q};
			msct_pkg::OP_H1X: return 33'(h1_q[0]);
			msct_pkg::OP_H1Y: return 33'(h1_q[1]);
			msct_pkg::OP_H1Z: return 33'(h1_q[2]);
			msct_pkg::OP_S1:  return {17'b0, s1_q};
			msct_pkg::OP_WX:  return 33'(w_q[0]);
			msct_pkg::OP_WY:  return 33'(w_q[1]);
			msct_pkg::OP_WZ:  return 33'(w_q[2]);
			msct_pkg::OP_PX:  return 33'(p_q[0]);
			msct_pkg::OP_PY:  return 33'(p_q[1]);
			msct_pkg::OP_PZ:  return 33'(p_q[2]);
			msct_pkg::OP_D:   return {16'b0, d_q};
			msct_pkg::OP_BLO: return {1'b0, babs_q[31:0]};
			msct_pkg::OP_BHI: return {11'b0, babs_q[53:32]};
			msct_pkg::OP_ALO: return {1'b0, a_q[31:0]};
			msct_pkg::OP_AHI: return {1'b0, a_q[63:32]};
			msct_pkg::OP_CLO: return {1'b0, cabs_q[31:0]};
			msct_pkg::OP_CHI: return {21'b0, cabs_q[43:32]};
			default:          return '0;
		endcase
	endfunction

	always_comb begin
		uop   = msct_pkg::ucode(cmd.step);
		mul_a = opnd_val(uop.sel_a);
		mul_b = opnd_val(uop.sel_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uop_s1 <= '0;
		end else begin
			uop_s1 <= cmd.mul_en ? uop : '0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 66'(mul_a) * 66'(mul_b);
	end

	// Disc addend: product placed at its partial-product offset
	logic signed [109:0] disc_add;
	logic                disc_sub;

	always_comb begin
		case (uop_s1.sh)
			msct_pkg::SH_32: disc_add = 110'(prod_s1) <<< 32;
			msct_pkg::SH_64: disc_add = 110'(prod_s1) <<< 64;
			default:         disc_add = 110'(prod_s1);
		endcase
		disc_sub = uop_s1.negc & c_nonneg_q;
	end

	// accumulators
	always_ff @(posedge clk) begin
		if (cmd.load_second) begin
			for (int i = 0; i < 3; i++)
				w_q[i] <= '0;
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
			disc_q <= '0;
		end else begin
			case (uop_s1.dst)
				msct_pkg::DST_W0: w_q[0] <= uop_s1.sub ? w_q[0] - $signed(prod_s1[31:0])
					: w_q[0] + $signed(prod_s1[31:0]);
				msct_pkg::DST_W1: w_q[1] <= uop_s1.sub ? w_q[1] - $signed(prod_s1[31:0])
					: w_q[1] + $signed(prod_s1[31:0]);
				msct_pkg::DST_W2: w_q[2] <= uop_s1.sub ? w_q[2] - $signed(prod_s1[31:0])
					: w_q[2] + $signed(prod_s1[31:0]);
				msct_pkg::DST_A:  a_q <= a_q + prod_s1[63:0];
				msct_pkg::DST_B:  b_q <= b_q + $signed(prod_s1[53:0]);
				msct_pkg::DST_C:  c_q <= uop_s1.sub ? c_q - $signed(prod_s1[43:0])
					: c_q + $signed(prod_s1[43:0]);
				msct_pkg::DST_DISC: disc_q <= disc_sub ? disc_q - disc_add : disc_q + disc_add;
				default: ;
			endcase
		end
	end

	// magnitudes for the wide products
	always_ff @(posedge clk) begin
		if (cmd.abs_en) begin
			babs_q     <= b_q[53] ? 54'(-b_q) : 54'(b_q);
			cabs_q     <= c_q[43] ? 44'(-c_q) : 44'(c_q);
			c_nonneg_q <= ~c_q[43];
		end
	end

	// integer square root, one result bit per cycle
	logic [109:0] rad_q;
	logic [57:0]  rem_q;
	logic [54:0]  root_q;
	logic [59:0]  rem_sh, trial;
	logic         sq_ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[109:108]};
		trial  = {3'b0, root_q, 2'b01};
		sq_ge  = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rad_q  <= disc_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[107:0], 2'b00};
			rem_q  <= sq_ge ? 58'(rem_sh - trial) : rem_sh[57:0];
			root_q <= {root_q[53:0], sq_ge};
		end
	end

	// root select: earlier crossing first, positive only
	logic signed [56:0] nb, sx, n1, n2;
	logic [55:0]        n_q;

	always_comb begin
		nb = -57'(b_q);
		sx = {2'b0, root_q};
		n2 = nb - sx;
		n1 = nb + sx;
	end

	always_ff @(posedge clk) begin
		if (cmd.root_en)
			n_q <= (n2 > 0) ? n2[55:0] : n1[55:0];
	end

	// restoring divide: floor(n * 2^28 / A), 16 quotient bits
	logic [63:0] dr_q;
	logic [15:0] q_q;
	logic [64:0] dr_sh;
	logic        dv_ge;

	always_comb begin
		dr_sh = {dr_q, 1'b0};
		dv_ge = (dr_sh >= {1'b0, a_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.q_clr) begin
			q_q <= '0;
		end else if (cmd.div_init) begin
			dr_q <= {n_q[51:0], 12'b0};
			q_q  <= '0;
		end else if (cmd.div_step) begin
			dr_q <= dv_ge ? 64'(dr_sh - {1'b0, a_q}) : dr_sh[63:0];
			q_q  <= {q_q[14:0], dv_ge};
		end
	end

	// result register with horizon limit
	logic [15:0] out_time_q;

	always_ff @(posedge clk) begin
		if (cmd.out_write)
			out_time_q <= (q_q <= horizon_q) ? q_q : '0;
	end

	assign out_time = out_time_q;

	always_comb begin
		status.far      = far_q;
		status.a_zero   = (a_q == '0);
		status.disc_neg = disc_q[109];
		status.no_root  = !(n2 > 0) && !(n1 > 0);
		status.too_big  = ({n_q, 12'b0} >= {4'b0, a_q});
	end

endmodule

>>> hw/rtl/moving_sphere_collision_time.sv
// ----------------------------------------------------------------------------
// moving_sphere_collision_time
// Time of impact of two moving spheres, fixed point.
// ----------------------------------------------------------------------------
// Input words on the s_ channel carry one body each. A word with s_tuser low
// loads the first body (no result). A word with s_tuser high gives
// the second body and produces exactly one result word on the m_ channel:
// impact_time in Q2.14, zero when no future contact lies within the horizon,
// and m_tuser set when the time is nonzero.
// A pair test runs from acceptance of the second body to the result through
// 16 products in one shared 33x33 multiplier, 8 more partial products for the
// discriminant, the bit-serial square root and the restoring divider, with
// decision steps between them. Early exits (far apart, equal velocities, no
// real or positive root, a time too large for the divider) finish sooner.
// s_tready is high only while no pair test is running. A finished result waits
// in the output register; a stalled receiver holds the sequencer in its last
// step, but a new first body may load while the result waits.
// Reset clears the held first body to zero and sets the horizon to 3.0.
// cfg_we writes cfg_wdata into the horizon register; write only when idle.
// ----------------------------------------------------------------------------
module moving_sphere_collision_time (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [15:0]                     cfg_wdata,  // time_horizon
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pos_z, head_x, head_y, head_z, speed, radius
	input  logic [8*msct_pkg::IN_BYTES-1:0] s_tdata,
	input  logic                            s_tuser,    // is_second
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,    // impact_time
	output logic                            m_tuser     // will_collide
);

	msct_pkg::cmd_t    cmd;
	msct_pkg::status_t status;
	logic [15:0]       out_time;

	msct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	msct_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.out_time  (out_time)
	);

	assign m_tdata = out_time;
	assign m_tuser = (out_time != '0);

`include "moving_sphere_collision_time_assert.svh"

	`MSCT_ASSERT_NOW(a_no_overwrite, cmd.out_write, !m_tvalid || m_tready, "result overwritten")
	`MSCT_ASSERT_NOW(a_flag_match, m_tvalid, m_tuser == (m_tdata != 16'd0), "flag mismatch")
	`MSCT_ASSERT_NEXT(a_busy_after_pair, s_tvalid && s_tready && s_tuser, !s_tready, "not busy")

endmodule
